FILE: sv/brb_pkg.sv
// ----------------------------------------------------------------------------
// brb_pkg
// shared constants, codes and control/status bundles of the byte ring buffer
// ----------------------------------------------------------------------------
package brb_pkg;

   // bytes held at most; the store has one spare slot on top
   localparam int CAPACITY = 1024;
   localparam int SLOTS    = CAPACITY + 1;

   // field widths fixed by the interface
   localparam int ACTION_W = 3;
   localparam int DATA_W   = 8;
   localparam int COUNT_W  = 11;
   localparam int SIZE_W   = 11;

   // pointer and store index width
   localparam int PTR_W    = $clog2(SLOTS);
   localparam int SUM_W    = ((PTR_W > COUNT_W) ? PTR_W : COUNT_W) + 2;

   typedef enum logic [ACTION_W-1:0] {
      ACT_PUSH        = 3'd0,
      ACT_WRITE_AHEAD = 3'd1,
      ACT_PEEK        = 3'd2,
      ACT_POP         = 3'd3,
      ACT_ADV_FRONT   = 3'd4,
      ACT_ADV_REAR    = 3'd5
   } action_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PEEK
   } ctl_state_type;

   // controller -> datapath
   typedef struct packed {
      logic in_load;     // capture a request into the item register
      logic clr_step;    // write one zero during the clearing sweep
      logic mem_we;      // write the item byte
      logic wr_at_tail;  // write address is the rear pointer itself
      logic mem_re;      // read the store at the offset slot
      logic base_head;   // slot adder starts from the front pointer
      logic amt_one;     // slot adder adds one instead of the count
      logic head_we;
      logic tail_we;
      logic rsp_load;    // capture ok and byte select for the result
      logic rsp_ok;
      logic rsp_rd_sel;
   } ctl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic                has_room;
      logic                ahead_ok;
      logic                peek_ok;
      logic                pop_ok;
      logic                clr_last;
   } dp_status_type;

   // (base + amount) mod SLOTS for amount below twice SLOTS beyond base
   function automatic logic [PTR_W-1:0] slot_add(input logic [PTR_W-1:0]   base,
                                                 input logic [COUNT_W-1:0] amount);
      logic [SUM_W-1:0] sum;
      logic [SUM_W-1:0] wrapped;
      sum = SUM_W'(base) + SUM_W'(amount);
      if (sum >= SUM_W'(2 * SLOTS)) begin
         wrapped = sum - SUM_W'(2 * SLOTS);
      end else if (sum >= SUM_W'(SLOTS)) begin
         wrapped = sum - SUM_W'(SLOTS);
      end else begin
         wrapped = sum;
      end
      return wrapped[PTR_W-1:0];
   endfunction

endpackage

FILE: sv/brb_ctrl.sv
// ----------------------------------------------------------------------------
// brb_ctrl
// sequencer of the byte ring buffer: clearing sweep, item dispatch, handshakes
// ----------------------------------------------------------------------------
module brb_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  brb_pkg::dp_status_type status,
   output brb_pkg::ctl_cmd_type   cmd
);

   brb_pkg::ctl_state_type state_ff, state_in;
   logic                   in_valid_ff, in_valid_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   in_take;
   logic                   rsp_set;
   logic                   out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= brb_pkg::ST_CLEAR;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign in_take   = (state_ff == brb_pkg::ST_IDLE) && in_valid_ff && out_free;
   assign req_ready = (state_ff != brb_pkg::ST_CLEAR) && (!in_valid_ff || in_take);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      rsp_set  = 1'b0;
      cmd.in_load = req_valid && req_ready;

      unique case (state_ff)
         brb_pkg::ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clr_last) begin
               state_in = brb_pkg::ST_IDLE;
            end
         end
         brb_pkg::ST_IDLE: begin
            if (in_take) begin
               cmd.rsp_load = 1'b1;
               rsp_set      = 1'b1;
               unique case (brb_pkg::action_type'(status.action))
                  brb_pkg::ACT_PUSH: begin
                     cmd.wr_at_tail = 1'b1;
                     cmd.amt_one    = 1'b1;
                     if (status.has_room) begin
                        cmd.mem_we  = 1'b1;
                        cmd.tail_we = 1'b1;
                        cmd.rsp_ok  = 1'b1;
                     end
                  end
                  brb_pkg::ACT_WRITE_AHEAD: begin
                     if (status.ahead_ok) begin
                        cmd.mem_we = 1'b1;
                        cmd.rsp_ok = 1'b1;
                     end
                  end
                  brb_pkg::ACT_PEEK: begin
                     cmd.base_head = 1'b1;
                     if (status.peek_ok) begin
                        cmd.mem_re     = 1'b1;
                        cmd.rsp_ok     = 1'b1;
                        cmd.rsp_rd_sel = 1'b1;
                        rsp_set        = 1'b0;
                        state_in       = brb_pkg::ST_PEEK;
                     end
                  end
                  brb_pkg::ACT_POP: begin
                     cmd.base_head = 1'b1;
                     if (status.pop_ok) begin
                        cmd.head_we = 1'b1;
                        cmd.rsp_ok  = 1'b1;
                     end
                  end
                  brb_pkg::ACT_ADV_FRONT: begin
                     cmd.base_head = 1'b1;
                     cmd.head_we   = 1'b1;
                     cmd.rsp_ok    = 1'b1;
                  end
                  brb_pkg::ACT_ADV_REAR: begin
                     cmd.tail_we = 1'b1;
                     cmd.rsp_ok  = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         brb_pkg::ST_PEEK: begin
            // read data lands this cycle, result goes out next
            rsp_set  = 1'b1;
            state_in = brb_pkg::ST_IDLE;
         end
         default: begin
            state_in = brb_pkg::ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      if (cmd.in_load) begin
         in_valid_in = 1'b1;
      end else if (in_take) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_comb begin
      if (rsp_set) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

endmodule

FILE: sv/brb_dp.sv
// ----------------------------------------------------------------------------
// brb_dp
// datapath of the byte ring buffer: item register, pointers, store, sizes
// ----------------------------------------------------------------------------
module brb_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  brb_pkg::ctl_cmd_type                 cmd,
   output brb_pkg::dp_status_type               status,
   input  logic [brb_pkg::ACTION_W-1:0]         req_action,
   input  logic [brb_pkg::DATA_W-1:0]           req_data_byte,
   input  logic [brb_pkg::COUNT_W-1:0]          req_count,
   output logic                                 rsp_ok,
   output logic [brb_pkg::DATA_W-1:0]           rsp_read_byte,
   output logic [brb_pkg::SIZE_W-1:0]           rsp_used_bytes,
   output logic [brb_pkg::SIZE_W-1:0]           rsp_free_bytes,
   output logic [brb_pkg::SIZE_W-1:0]           rsp_run_used,
   output logic [brb_pkg::SIZE_W-1:0]           rsp_run_free
);

   localparam int PTR_W  = brb_pkg::PTR_W;
   localparam int SIZE_W = brb_pkg::SIZE_W;

   // item register
   logic [brb_pkg::ACTION_W-1:0] act_ff;
   logic [brb_pkg::DATA_W-1:0]   data_ff;
   logic [brb_pkg::COUNT_W-1:0]  count_ff;

   // pointers and clearing sweep
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [PTR_W-1:0] clr_cnt_ff, clr_cnt_in;

   // result register
   logic                       ok_ff;
   logic                       rd_sel_ff;
   logic [brb_pkg::DATA_W-1:0] rd_data_ff;

   // store
   logic [brb_pkg::DATA_W-1:0] mem [brb_pkg::SLOTS];
   logic                       wr_en;
   logic [PTR_W-1:0]           wr_addr;
   logic [brb_pkg::DATA_W-1:0] wr_data;

   logic [PTR_W-1:0]            base;
   logic [brb_pkg::COUNT_W-1:0] amount;
   logic [PTR_W-1:0]            slot;
   logic [PTR_W:0]              used_w;
   logic [SIZE_W-1:0]           used;
   logic [SIZE_W-1:0]           free;

   always_ff @(posedge clock) begin
      if (cmd.in_load) begin
         act_ff   <= req_action;
         data_ff  <= req_data_byte;
         count_ff <= req_count;
      end
      if (cmd.rsp_load) begin
         ok_ff     <= cmd.rsp_ok;
         rd_sel_ff <= cmd.rsp_rd_sel;
      end
      if (cmd.mem_re) begin
         rd_data_ff <= mem[slot];
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff    <= '0;
         tail_ff    <= '0;
         clr_cnt_ff <= '0;
      end else begin
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   // one shared modular adder for addresses and pointer moves
   assign base   = cmd.base_head ? head_ff : tail_ff;
   assign amount = cmd.amt_one ? brb_pkg::COUNT_W'(1) : count_ff;
   assign slot   = brb_pkg::slot_add(base, amount);

   assign head_in    = cmd.head_we ? slot : head_ff;
   assign tail_in    = cmd.tail_we ? slot : tail_ff;
   assign clr_cnt_in = cmd.clr_step ? clr_cnt_ff + PTR_W'(1) : clr_cnt_ff;

   always_comb begin
      if (cmd.clr_step) begin
         wr_en   = 1'b1;
         wr_addr = clr_cnt_ff;
         wr_data = '0;
      end else begin
         wr_en   = cmd.mem_we;
         wr_addr = cmd.wr_at_tail ? tail_ff : slot;
         wr_data = data_ff;
      end
   end

   // occupancy from the pointers
   always_comb begin
      if (tail_ff >= head_ff) begin
         used_w = {1'b0, tail_ff} - {1'b0, head_ff};
      end else begin
         used_w = {1'b0, tail_ff} + (PTR_W + 1)'(brb_pkg::SLOTS) - {1'b0, head_ff};
      end
   end

   assign used = SIZE_W'(used_w);
   assign free = SIZE_W'(brb_pkg::CAPACITY) - used;

   always_comb begin
      if (head_ff <= tail_ff) begin
         rsp_run_used = SIZE_W'(tail_ff - head_ff);
      end else begin
         rsp_run_used = SIZE_W'(brb_pkg::SLOTS) - SIZE_W'(head_ff);
      end
      if (head_ff > tail_ff) begin
         rsp_run_free = SIZE_W'(head_ff - tail_ff - PTR_W'(1));
      end else if (head_ff == '0) begin
         rsp_run_free = SIZE_W'(brb_pkg::SLOTS - 1) - SIZE_W'(tail_ff);
      end else begin
         rsp_run_free = SIZE_W'(brb_pkg::SLOTS) - SIZE_W'(tail_ff);
      end
   end

   assign status.action   = act_ff;
   assign status.has_room = used < SIZE_W'(brb_pkg::CAPACITY);
   assign status.ahead_ok = SIZE_W'(count_ff) < free;
   assign status.peek_ok  = SIZE_W'(count_ff) < used;
   assign status.pop_ok   = SIZE_W'(count_ff) <= used;
   assign status.clr_last = clr_cnt_ff == PTR_W'(brb_pkg::SLOTS - 1);

   assign rsp_ok         = ok_ff;
   assign rsp_read_byte  = rd_sel_ff ? rd_data_ff : '0;
   assign rsp_used_bytes = used;
   assign rsp_free_bytes = free;

endmodule

FILE: sv/byte_ring_buffer_top.sv
// ----------------------------------------------------------------------------
// byte_ring_buffer_top
// circular byte fifo of CAPACITY bytes with one spare slot
// ----------------------------------------------------------------------------
// each request does one action (push, write ahead of the rear, peek at an
// offset from the front, checked pop, unchecked front or rear advance) and
// yields exactly one response with the ok flag, the peeked byte and the used,
// free and contiguous run sizes after the action. after reset the block runs
// a clearing sweep that zeroes all CAPACITY+1 byte slots of the store, one
// slot a cycle; req_ready stays low until it ends. a request is buffered in
// an item register and executed through a single modular adder and one store
// port, so all actions but a successful peek sustain one transfer per cycle
// while no response stalls; a successful peek also passes through ST_PEEK
// because the store read is registered. a request executes only once the
// previous response has been taken or is being taken; the size fields
// follow the pointer registers, which do not move while a response waits.
// ----------------------------------------------------------------------------
module byte_ring_buffer_top (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [brb_pkg::ACTION_W-1:0]  req_action,
   input  logic [brb_pkg::DATA_W-1:0]    req_data_byte,
   input  logic [brb_pkg::COUNT_W-1:0]   req_count,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_ok,
   output logic [brb_pkg::DATA_W-1:0]    rsp_read_byte,
   output logic [brb_pkg::SIZE_W-1:0]    rsp_used_bytes,
   output logic [brb_pkg::SIZE_W-1:0]    rsp_free_bytes,
   output logic [brb_pkg::SIZE_W-1:0]    rsp_run_used,
   output logic [brb_pkg::SIZE_W-1:0]    rsp_run_free
);

   // command and status between sequencer and datapath
   brb_pkg::ctl_cmd_type   cmd;
   brb_pkg::dp_status_type status;

   // sequencer: clearing sweep, dispatch by action, transfer handshakes
   brb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: item register, pointers, byte store, size arithmetic
   brb_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_action     (req_action),
      .req_data_byte  (req_data_byte),
      .req_count      (req_count),
      .rsp_ok         (rsp_ok),
      .rsp_read_byte  (rsp_read_byte),
      .rsp_used_bytes (rsp_used_bytes),
      .rsp_free_bytes (rsp_free_bytes),
      .rsp_run_used   (rsp_run_used),
      .rsp_run_free   (rsp_run_free)
   );

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the byte ring buffer: a short table of directed
// transfers, then about 1500 random ones, each response checked field by field
// against its table literal, else a shadow of the store and the two pointers
// ----------------------------------------------------------------------------
module tb;

   // run shape
   localparam int RANDOM_ITEMS   = 1500;
   localparam int STALL_PCT      = 17;
   localparam int QUIET_FIRST    = 600;    // random items in this window never idle
   localparam int QUIET_LAST     = 899;
   localparam int WATCHDOG_LIMIT = 4000;   // covers the clearing sweep
   localparam int DRAIN_CYCLES   = 8;

   // action codes the block does not define; they must change nothing
   localparam logic [brb_pkg::ACTION_W-1:0] ACT_RESERVED_A = 3'd6;
   localparam logic [brb_pkg::ACTION_W-1:0] ACT_RESERVED_B = 3'd7;

   // one response as the block reports it
   typedef struct packed {
      logic                       ok;
      logic [brb_pkg::DATA_W-1:0] read_byte;
      logic [brb_pkg::SIZE_W-1:0] used_bytes;
      logic [brb_pkg::SIZE_W-1:0] free_bytes;
      logic [brb_pkg::SIZE_W-1:0] run_used;
      logic [brb_pkg::SIZE_W-1:0] run_free;
   } ring_report_type;

   // one row of the directed table; has_lit selects the typed-in response
   typedef struct packed {
      logic [brb_pkg::ACTION_W-1:0] action;
      logic [brb_pkg::DATA_W-1:0]   data_byte;
      logic [brb_pkg::COUNT_W-1:0]  count;
      logic                         has_lit;
      ring_report_type              lit;
   } plan_row_type;

   localparam ring_report_type NO_LIT = '0;

   // response literals: ok, read byte, used, free, used run, free run
   localparam int PLAN_LEN = 26;
   localparam plan_row_type PLAN [PLAN_LEN] = '{
      // empty after reset: peek and pop of one fail, pop of zero succeeds
      '{brb_pkg::ACT_PEEK,        8'h00, 11'd0,    1'b1,
        '{1'b0, 8'h00, 11'd0, 11'd1024, 11'd0, 11'd1024}},
      '{brb_pkg::ACT_POP,         8'h00, 11'd1,    1'b1,
        '{1'b0, 8'h00, 11'd0, 11'd1024, 11'd0, 11'd1024}},
      '{brb_pkg::ACT_POP,         8'h00, 11'd0,    1'b1,
        '{1'b1, 8'h00, 11'd0, 11'd1024, 11'd0, 11'd1024}},
      // write ahead: offset equal to free fails, one below succeeds
      '{brb_pkg::ACT_WRITE_AHEAD, 8'hA5, 11'd1024, 1'b1,
        '{1'b0, 8'h00, 11'd0, 11'd1024, 11'd0, 11'd1024}},
      '{brb_pkg::ACT_WRITE_AHEAD, 8'hA5, 11'd1023, 1'b1,
        '{1'b1, 8'h00, 11'd0, 11'd1024, 11'd0, 11'd1024}},
      '{brb_pkg::ACT_PUSH,        8'hFF, 11'd0,    1'b1,
        '{1'b1, 8'h00, 11'd1, 11'd1023, 11'd1, 11'd1023}},
      '{brb_pkg::ACT_PUSH,        8'h00, 11'd0,    1'b1,
        '{1'b1, 8'h00, 11'd2, 11'd1022, 11'd2, 11'd1022}},
      '{brb_pkg::ACT_PEEK,        8'h00, 11'd0,    1'b1,
        '{1'b1, 8'hFF, 11'd2, 11'd1022, 11'd2, 11'd1022}},
      '{brb_pkg::ACT_PEEK,        8'h00, 11'd1,    1'b1,
        '{1'b1, 8'h00, 11'd2, 11'd1022, 11'd2, 11'd1022}},
      '{brb_pkg::ACT_PEEK,        8'h00, 11'd2,    1'b1,
        '{1'b0, 8'h00, 11'd2, 11'd1022, 11'd2, 11'd1022}},
      // rear jump to one below full, then the last push fills it
      '{brb_pkg::ACT_ADV_REAR,    8'h00, 11'd1021, 1'b1,
        '{1'b1, 8'h00, 11'd1023, 11'd1, 11'd1023, 11'd1}},
      '{brb_pkg::ACT_PEEK,        8'h00, 11'd1022, 1'b0, NO_LIT},
      '{brb_pkg::ACT_PUSH,        8'h5A, 11'd0,    1'b1,
        '{1'b1, 8'h00, 11'd1024, 11'd0, 11'd1024, 11'd0}},
      // full: push and write ahead fail without growth, oversize pop fails
      '{brb_pkg::ACT_PUSH,        8'h33, 11'd0,    1'b1,
        '{1'b0, 8'h00, 11'd1024, 11'd0, 11'd1024, 11'd0}},
      '{brb_pkg::ACT_WRITE_AHEAD, 8'h33, 11'd0,    1'b1,
        '{1'b0, 8'h00, 11'd1024, 11'd0, 11'd1024, 11'd0}},
      '{brb_pkg::ACT_POP,         8'h00, 11'd2047, 1'b1,
        '{1'b0, 8'h00, 11'd1024, 11'd0, 11'd1024, 11'd0}},
      '{brb_pkg::ACT_PEEK,        8'h00, 11'd1023, 1'b0, NO_LIT},
      // drain all, then pushes wrap the rear around the store end
      '{brb_pkg::ACT_POP,         8'h00, 11'd1024, 1'b1,
        '{1'b1, 8'h00, 11'd0, 11'd1024, 11'd0, 11'd1}},
      '{brb_pkg::ACT_PUSH,        8'h81, 11'd0,    1'b1,
        '{1'b1, 8'h00, 11'd1, 11'd1023, 11'd1, 11'd1023}},
      '{brb_pkg::ACT_PUSH,        8'h7E, 11'd0,    1'b0, NO_LIT},
      '{brb_pkg::ACT_PEEK,        8'h00, 11'd1,    1'b0, NO_LIT},
      // unchecked front advance past the rear, with the largest count
      '{brb_pkg::ACT_ADV_FRONT,   8'h00, 11'd2047, 1'b0, NO_LIT},
      '{ACT_RESERVED_A,           8'h55, 11'd3,    1'b0, NO_LIT},
      '{ACT_RESERVED_B,           8'hAA, 11'd2047, 1'b0, NO_LIT},
      '{brb_pkg::ACT_ADV_REAR,    8'h00, 11'd0,    1'b0, NO_LIT},
      '{brb_pkg::ACT_POP,         8'h00, 11'd1,    1'b0, NO_LIT}
   };

   logic                         clock          = 1'b0;
   logic                         reset          = 1'b1;
   logic                         req_valid      = 1'b0;
   logic                         req_ready;
   logic [brb_pkg::ACTION_W-1:0] req_action     = '0;
   logic [brb_pkg::DATA_W-1:0]   req_data_byte  = '0;
   logic [brb_pkg::COUNT_W-1:0]  req_count      = '0;
   logic                         rsp_valid;
   logic                         rsp_ready      = 1'b0;
   logic                         rsp_ok;
   logic [brb_pkg::DATA_W-1:0]   rsp_read_byte;
   logic [brb_pkg::SIZE_W-1:0]   rsp_used_bytes;
   logic [brb_pkg::SIZE_W-1:0]   rsp_free_bytes;
   logic [brb_pkg::SIZE_W-1:0]   rsp_run_used;
   logic [brb_pkg::SIZE_W-1:0]   rsp_run_free;

   // typed-in response that rides along with the current request
   logic                         req_has_lit    = 1'b0;
   ring_report_type              req_lit        = '0;

   // shadow of the block: byte store and the two pointers
   logic [brb_pkg::DATA_W-1:0]   shadow_bytes [brb_pkg::SLOTS];
   int unsigned                  front_ptr;
   int unsigned                  rear_ptr;

   ring_report_type              pending_reports [$];
   int unsigned                  fail_count     = 0;
   int unsigned                  quiet_cycles   = 0;
   logic                         calm           = 1'b0;   // no idling on either side
   logic                         filling        = 1'b1;   // random mix leans toward pushes

   byte_ring_buffer_top DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_data_byte  (req_data_byte),
      .req_count      (req_count),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_ok         (rsp_ok),
      .rsp_read_byte  (rsp_read_byte),
      .rsp_used_bytes (rsp_used_bytes),
      .rsp_free_bytes (rsp_free_bytes),
      .rsp_run_used   (rsp_run_used),
      .rsp_run_free   (rsp_run_free)
   );

   // 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // shadow of the ring
   // ------------------------------------------------------------------------

   // equal pointers mean empty, so the spare slot keeps full and empty apart
   function automatic int unsigned held_count();
      if (rear_ptr >= front_ptr) begin
         return rear_ptr - front_ptr;
      end
      return rear_ptr + brb_pkg::SLOTS - front_ptr;
   endfunction

   // used bytes readable from the front before the store end
   function automatic int unsigned held_run();
      return (front_ptr <= rear_ptr) ? rear_ptr - front_ptr : brb_pkg::SLOTS - front_ptr;
   endfunction

   // free bytes writable from the rear before the store end or the spare slot
   function automatic int unsigned room_run();
      if (front_ptr > rear_ptr) begin
         return front_ptr - rear_ptr - 1;
      end
      return brb_pkg::SLOTS - rear_ptr - ((front_ptr == 0) ? 1 : 0);
   endfunction

   function automatic int unsigned wrap_slot(int unsigned base, int unsigned amount);
      return (base + amount) % brb_pkg::SLOTS;
   endfunction

   // carry out one request on the shadow and report what the block should say
   function automatic ring_report_type apply_request(
         logic [brb_pkg::ACTION_W-1:0] act,
         logic [brb_pkg::DATA_W-1:0]   dat,
         logic [brb_pkg::COUNT_W-1:0]  cnt);
      ring_report_type rep;
      int unsigned     held;
      int unsigned     room;
      int unsigned     amount;
      held   = held_count();
      room   = brb_pkg::CAPACITY - held;
      amount = 32'(cnt);
      rep    = '0;
      case (act)
         brb_pkg::ACT_PUSH: begin
            // full push fails, there is no growth
            if (held < brb_pkg::CAPACITY) begin
               shadow_bytes[rear_ptr] = dat;
               rear_ptr = wrap_slot(rear_ptr, 1);
               rep.ok = 1'b1;
            end
         end
         brb_pkg::ACT_WRITE_AHEAD: begin
            if (amount < room) begin
               shadow_bytes[wrap_slot(rear_ptr, amount)] = dat;
               rep.ok = 1'b1;
            end
         end
         brb_pkg::ACT_PEEK: begin
            if (amount < held) begin
               rep.read_byte = shadow_bytes[wrap_slot(front_ptr, amount)];
               rep.ok = 1'b1;
            end
         end
         brb_pkg::ACT_POP: begin
            if (amount <= held) begin
               front_ptr = wrap_slot(front_ptr, amount);
               rep.ok = 1'b1;
            end
         end
         // unchecked moves: overrunning the other pointer just changes the count
         brb_pkg::ACT_ADV_FRONT: begin
            front_ptr = wrap_slot(front_ptr, amount);
            rep.ok = 1'b1;
         end
         brb_pkg::ACT_ADV_REAR: begin
            rear_ptr = wrap_slot(rear_ptr, amount);
            rep.ok = 1'b1;
         end
         default: begin
         end
      endcase
      held = held_count();
      rep.used_bytes = brb_pkg::SIZE_W'(held);
      rep.free_bytes = brb_pkg::SIZE_W'(brb_pkg::CAPACITY - held);
      rep.run_used   = brb_pkg::SIZE_W'(held_run());
      rep.run_free   = brb_pkg::SIZE_W'(room_run());
      return rep;
   endfunction

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------

   // random request shaped by the shadow's fill level; the mix swings between
   // filling and draining so both full and empty come up again and again
   task automatic pick_request(output logic [brb_pkg::ACTION_W-1:0] act,
                               output logic [brb_pkg::DATA_W-1:0]   dat,
                               output logic [brb_pkg::COUNT_W-1:0]  cnt);
      int unsigned held;
      int unsigned room;
      int unsigned roll;
      int unsigned amount;
      int unsigned w_push;
      int unsigned w_rear;
      int unsigned w_pop;
      int unsigned w_front;
      held = held_count();
      room = brb_pkg::CAPACITY - held;
      if (room == 0) begin
         filling = 1'b0;
      end else if (held == 0) begin
         filling = 1'b1;
      end else if ($urandom_range(0, 199) == 0) begin
         filling = !filling;
      end
      w_push  = filling ? 40 : 14;
      w_rear  = filling ? 6  : 2;
      w_pop   = filling ? 8  : 26;
      w_front = filling ? 2  : 14;
      roll    = $urandom_range(0, 99);
      dat     = brb_pkg::DATA_W'($urandom);
      act     = brb_pkg::ACT_PEEK;
      if (roll < 6) begin
         // noise: any code, any count the port carries
         act    = brb_pkg::ACTION_W'($urandom_range(0, 7));
         amount = $urandom_range(0, 2047);
      end else if (roll < 6 + w_push) begin
         act    = brb_pkg::ACT_PUSH;
         amount = $urandom_range(0, 2047);
      end else if (roll < 6 + w_push + w_rear) begin
         // commit a block of free space at once
         act    = brb_pkg::ACT_ADV_REAR;
         amount = $urandom_range(0, room);
      end else if (roll < 18 + w_push + w_rear) begin
         act    = brb_pkg::ACT_WRITE_AHEAD;
         if (room == 0 || $urandom_range(0, 7) == 0) begin
            amount = room;
         end else begin
            amount = $urandom_range(0, room - 1);
         end
      end else if (roll < 18 + w_push + w_rear + w_pop) begin
         act    = brb_pkg::ACT_POP;
         if ($urandom_range(0, 9) == 0) begin
            amount = held + 1;
         end else begin
            amount = $urandom_range(0, filling ? ((held < 4) ? held : 4) : held);
         end
      end else if (roll < 18 + w_push + w_rear + w_pop + w_front) begin
         act    = brb_pkg::ACT_ADV_FRONT;
         amount = $urandom_range(0, held);
      end else begin
         if (held == 0 || $urandom_range(0, 7) == 0) begin
            amount = $urandom_range(held, brb_pkg::CAPACITY);
         end else begin
            amount = $urandom_range(0, held - 1);
         end
      end
      cnt = brb_pkg::COUNT_W'(amount);
   endtask

   // called at a falling edge: idle for a random while, then hold the request
   // until the block takes it; returns at the accepting rising edge
   task automatic issue(input logic [brb_pkg::ACTION_W-1:0] act,
                        input logic [brb_pkg::DATA_W-1:0]   dat,
                        input logic [brb_pkg::COUNT_W-1:0]  cnt,
                        input logic                         has_lit,
                        input ring_report_type              lit);
      while (!calm && $urandom_range(0, 99) < STALL_PCT) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid     = 1'b1;
      req_action    = act;
      req_data_byte = dat;
      req_count     = cnt;
      req_has_lit   = has_lit;
      req_lit       = lit;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
   endtask

   // response side stalls on its own
   always @(negedge clock) begin
      rsp_ready = calm || ($urandom_range(0, 99) >= STALL_PCT);
   end

   // ------------------------------------------------------------------------
   // checking
   // ------------------------------------------------------------------------

   task automatic compare_field(input string field, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         $error("%s expected %0d got %0d", field, want, got);
         fail_count++;
      end
   endtask

   // responses are checked before the request of the same edge is predicted,
   // so the queue order always matches the block's order
   always @(posedge clock) begin
      ring_report_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_reports.size() == 0) begin
               $error("response transfer with no request outstanding");
               fail_count++;
            end else begin
               want = pending_reports.pop_front();
               compare_field("ok",         32'(want.ok),         32'(rsp_ok));
               compare_field("read_byte",  32'(want.read_byte),  32'(rsp_read_byte));
               compare_field("used_bytes", 32'(want.used_bytes), 32'(rsp_used_bytes));
               compare_field("free_bytes", 32'(want.free_bytes), 32'(rsp_free_bytes));
               compare_field("run_used",   32'(want.run_used),   32'(rsp_run_used));
               compare_field("run_free",   32'(want.run_free),   32'(rsp_run_free));
            end
         end
         if (req_valid && req_ready) begin
            // the shadow always advances; a typed-in row overrides its answer
            want = apply_request(req_action, req_data_byte, req_count);
            if (req_has_lit) begin
               want = req_lit;
            end
            pending_reports.push_back(want);
         end
      end
   end

   // watchdog: too long without any transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------------
   initial begin
      logic [brb_pkg::ACTION_W-1:0] act;
      logic [brb_pkg::DATA_W-1:0]   dat;
      logic [brb_pkg::COUNT_W-1:0]  cnt;
      // store is cleared by reset, so the shadow starts all zeros
      for (int i = 0; i < brb_pkg::SLOTS; i++) begin
         shadow_bytes[i] = '0;
      end
      front_ptr = 0;
      rear_ptr  = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table; the first transfer also waits out the clearing sweep
      for (int r = 0; r < PLAN_LEN; r++) begin
         @(negedge clock);
         issue(PLAN[r].action, PLAN[r].data_byte, PLAN[r].count, PLAN[r].has_lit,
               PLAN[r].lit);
      end

      // random part, with a stretch where neither side idles
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         @(negedge clock);
         calm = (n >= QUIET_FIRST) && (n <= QUIET_LAST);
         pick_request(act, dat, cnt);
         issue(act, dat, cnt, 1'b0, NO_LIT);
      end
      @(negedge clock);
      req_valid   = 1'b0;
      req_has_lit = 1'b0;

      while (pending_reports.size() != 0) begin
         @(posedge clock);
      end
      // keep the clock running for the drain window to catch any stray response
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

FILE: files.f
sv/brb_pkg.sv
sv/brb_ctrl.sv
sv/brb_dp.sv
sv/byte_ring_buffer_top.sv
tb/tb.sv
